// ----- design/ccd_pkg.sv -----
// Package for the countdown clock display block: widths, codes, constants
// and the two-digit BCD helper. No dependencies.
package ccd_pkg;

	localparam int TIME_WIDTH_DEF = 23;

	localparam int KIND_W     = 3;
	localparam int SHOW_W     = 23;
	localparam int DIGITS_W   = 16;
	localparam int MODE_W     = 2;
	localparam int SEG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FLASH_W    = 10;
	localparam int SPINSTEP_W = 8;
	localparam int SPINIDX_W  = 3;

	localparam int FLASH_RST = 200;
	localparam int SPIN_RST  = 60;
	localparam int SPIN_LAST = 5;

	localparam int MS_PER_S     = 1000;
	localparam int FINE_STEP    = 10;
	localparam int FINE_ZONE_MS = 60000;
	localparam int SEC_PER_MIN  = 60;

	// Digit conversion works on values below the display clamp.
	localparam int CONV_W        = 23;
	localparam int SHOW_CLAMP_MS = 6000000;
	localparam int QUOT_W        = 13;
	localparam int REM_W         = 10;
	localparam int PAIR_W        = 7;
	localparam int TOP_HI        = 99;
	localparam int TOP_LO        = 59;

	// Reciprocals, exact over the ranges used.
	localparam int RECIP_1000    = 4294968;
	localparam int RECIP_1000_SH = 32;
	localparam int RECIP_60      = 8739;
	localparam int RECIP_60_W    = 14;
	localparam int RECIP_60_SH   = 19;
	localparam int RECIP_10      = 205;
	localparam int RECIP_10_W    = 8;
	localparam int RECIP_10_SH   = 11;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIN  = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 3'd0,
		KIND_START = 3'd1,
		KIND_STOP  = 3'd2,
		KIND_RESET = 3'd3,
		KIND_SPIN  = 3'd4,
		KIND_FLASH = 3'd5,
		KIND_SHOW  = 3'd6
	} ccd_kind_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_DIGITS = 2'd0,
		MODE_BLANK  = 2'd1,
		MODE_SPIN   = 2'd2
	} ccd_mode_t;

	typedef struct packed {
		ccd_mode_t          show_mode;
		logic [SEG_W-1:0]   spin_segments;
		logic               beep;
		logic               expired;
		logic               running;
	} ccd_flags_t;

	// Double dabble for a value below 100.
	function automatic logic [7:0] bcd2(input logic [PAIR_W-1:0] bin);
		logic [14:0] sh;
		sh = {8'd0, bin};
		for (int i = 0; i < PAIR_W; i++) begin
			if (sh[10:7] >= 4'd5) sh[10:7] = sh[10:7] + 4'd3;
			if (sh[14:11] >= 4'd5) sh[14:11] = sh[14:11] + 4'd3;
			sh = sh << 1;
		end
		return sh[14:7];
	endfunction

endpackage

// ----- design/ccd_if.sv -----
// Valid/ready channel interfaces of the countdown clock display: item,
// result and configuration write. Depends on ccd_pkg.
interface ccd_in_if;
	logic                         valid;
	logic                         ready;
	logic [ccd_pkg::KIND_W-1:0]   kind;
	logic [ccd_pkg::SHOW_W-1:0]   show_time_ms;
	modport source (output valid, kind, show_time_ms, input ready);
	modport sink   (input valid, kind, show_time_ms, output ready);
endinterface

interface ccd_out_if;
	logic                          valid;
	logic                          ready;
	logic [ccd_pkg::DIGITS_W-1:0]  digits_bcd;
	logic [ccd_pkg::MODE_W-1:0]    show_mode;
	logic [ccd_pkg::SEG_W-1:0]     spin_segments;
	logic                          beep;
	logic                          expired;
	logic                          running;
	modport source (output valid, digits_bcd, show_mode, spin_segments, beep, expired,
		running, input ready);
	modport sink   (input valid, digits_bcd, show_mode, spin_segments, beep, expired,
		running, output ready);
endinterface

interface ccd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ccd_pkg::CFG_IDX_W-1:0]   index;
	logic [ccd_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ccd_front.sv -----
// Front end: takes items and config writes, updates the timer, flash and
// spin state and pushes the shown time plus flags to the queue.
// Depends on ccd_pkg and ccd_if.
module ccd_front #(
	parameter int TIME_WIDTH = ccd_pkg::TIME_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ccd_in_if.sink                  item,
	ccd_cfg_if.sink                 cfg,
	output logic                    q_valid,
	input  logic                    q_ready,
	output logic [TIME_WIDTH-1:0]   q_time,
	output ccd_pkg::ccd_flags_t     q_flags
);

	localparam int TW  = TIME_WIDTH;
	localparam int TW1 = TIME_WIDTH + 1;
	localparam int CW  = ccd_pkg::CONV_W;
	localparam int EW  = (TW > CW) ? TW : CW;
	localparam int FW  = ccd_pkg::FLASH_W;
	localparam int SSW = ccd_pkg::SPINSTEP_W;
	localparam int SIW = ccd_pkg::SPINIDX_W;
	localparam int SGW = ccd_pkg::SEG_W;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	logic [TW-1:0]  lim_q;
	logic [FW-1:0]  fhp_q;
	logic [SSW-1:0] ssm_q;

	logic           run_q, flash_q, spin_q, phase_q, blank_q;
	logic [TW-1:0]  elapsed_q, nupd_q, nbeep_q, shown_q;
	logic [SIW-1:0] spin_idx_q;
	logic [SSW-1:0] spin_wait_q;
	logic [FW-1:0]  flash_wait_q;

	logic           nx_run, nx_flash, nx_spin, nx_phase, nx_blank;
	logic [TW-1:0]  nx_elapsed, nx_nupd, nx_nbeep, nx_shown;
	logic [SIW-1:0] nx_idx;
	logic [SSW-1:0] nx_swait;
	logic [FW-1:0]  nx_fwait;
	logic           nx_beep, nx_expired;

	logic           acc;
	logic [CW-1:0]  lim_prod;
	logic [EW-1:0]  lim_ext, show_ext;
	logic [TW-1:0]  lim_sat, show_sat;
	logic [TW-1:0]  e_inc, lim_left;
	logic           fine_zone;
	logic [TW:0]    upd_step, nu_sum, nb_sum;
	logic [TW-1:0]  nu_next, nb_next;
	logic [SGW-1:0] seg;

	assign cfg.ready  = 1'b1;
	assign item.ready = q_ready;
	assign acc        = item.valid && q_ready;

	assign lim_prod = CW'(cfg.data) * CW'(ccd_pkg::MS_PER_S);
	assign lim_ext  = EW'(lim_prod);
	assign lim_sat  = (lim_ext > EW'(TMAX)) ? TMAX : TW'(lim_ext);
	assign show_ext = EW'(item.show_time_ms);
	assign show_sat = (show_ext > EW'(TMAX)) ? TMAX : TW'(show_ext);

	assign e_inc     = (elapsed_q == TMAX) ? elapsed_q : elapsed_q + TW'(1);
	assign lim_left  = lim_q - e_inc;
	assign fine_zone = lim_left <= TW'(ccd_pkg::FINE_ZONE_MS);
	assign upd_step  = fine_zone ? TW1'(ccd_pkg::FINE_STEP) : TW1'(ccd_pkg::MS_PER_S);
	assign nu_sum    = {1'b0, nupd_q} + upd_step;
	assign nb_sum    = {1'b0, nbeep_q} + TW1'(ccd_pkg::MS_PER_S);
	assign nu_next   = nu_sum[TW] ? TMAX : nu_sum[TW-1:0];
	assign nb_next   = nb_sum[TW] ? TMAX : nb_sum[TW-1:0];

	always_comb begin
		nx_run     = run_q;
		nx_flash   = flash_q;
		nx_spin    = spin_q;
		nx_phase   = phase_q;
		nx_blank   = blank_q;
		nx_elapsed = elapsed_q;
		nx_nupd    = nupd_q;
		nx_nbeep   = nbeep_q;
		nx_shown   = shown_q;
		nx_idx     = spin_idx_q;
		nx_swait   = spin_wait_q;
		nx_fwait   = flash_wait_q;
		nx_beep    = 1'b0;
		nx_expired = 1'b0;
		case (ccd_pkg::ccd_kind_t'(item.kind))
			ccd_pkg::KIND_TICK: begin
				if (run_q) begin
					nx_elapsed = e_inc;
					if (e_inc >= lim_q) begin
						nx_shown   = '0;
						nx_spin    = 1'b0;
						nx_blank   = 1'b0;
						nx_run     = 1'b0;
						nx_expired = 1'b1;
					end else begin
						// elapsed never runs more than one past the schedule
						if (e_inc >= nupd_q) begin
							nx_shown = lim_q - nupd_q;
							nx_spin  = 1'b0;
							nx_blank = 1'b0;
							nx_nupd  = nu_next;
						end
						if (e_inc >= nbeep_q) begin
							nx_beep  = 1'b1;
							nx_nbeep = nb_next;
						end
					end
				end
				if (flash_q) begin
					if (flash_wait_q <= FW'(1)) begin
						nx_phase = !phase_q;
						if (!phase_q) begin
							nx_spin  = 1'b0;
							nx_blank = 1'b0;
						end else begin
							nx_blank = 1'b1;
						end
						nx_fwait = fhp_q;
					end else begin
						nx_fwait = flash_wait_q - FW'(1);
					end
				end
				if (nx_spin) begin
					if (spin_wait_q <= SSW'(1)) begin
						nx_idx   = (spin_idx_q >= SIW'(ccd_pkg::SPIN_LAST)) ? '0
							: spin_idx_q + SIW'(1);
						nx_swait = ssm_q;
					end else begin
						nx_swait = spin_wait_q - SSW'(1);
					end
				end
			end
			ccd_pkg::KIND_START: begin
				nx_elapsed = '0;
				nx_nupd    = '0;
				nx_nbeep   = '0;
				nx_run     = 1'b1;
				nx_flash   = 1'b0;
			end
			ccd_pkg::KIND_STOP: begin
				nx_run = 1'b0;
			end
			ccd_pkg::KIND_RESET: begin
				nx_run   = 1'b0;
				nx_flash = 1'b0;
				nx_spin  = 1'b0;
				nx_blank = 1'b0;
				nx_shown = lim_q;
			end
			ccd_pkg::KIND_SPIN: begin
				nx_spin  = 1'b1;
				nx_flash = 1'b0;
				nx_idx   = '0;
				nx_swait = ssm_q;
			end
			ccd_pkg::KIND_FLASH: begin
				nx_flash = 1'b1;
				nx_phase = !phase_q;
				if (!phase_q) begin
					nx_spin  = 1'b0;
					nx_blank = 1'b0;
				end else begin
					nx_blank = 1'b1;
				end
				nx_fwait = fhp_q;
			end
			ccd_pkg::KIND_SHOW: begin
				nx_spin  = 1'b0;
				nx_blank = 1'b0;
				nx_shown = show_sat;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		seg = '0;
		if (nx_spin) begin
			seg = (nx_idx > SIW'(ccd_pkg::SPIN_LAST)) ? SGW'(1) : SGW'(SGW'(1) << nx_idx);
		end
	end

	always_comb begin
		q_valid               = item.valid;
		q_time                = nx_shown;
		q_flags.show_mode     = nx_spin ? ccd_pkg::MODE_SPIN
			: (nx_blank ? ccd_pkg::MODE_BLANK : ccd_pkg::MODE_DIGITS);
		q_flags.spin_segments = seg;
		q_flags.beep          = nx_beep;
		q_flags.expired       = nx_expired;
		q_flags.running       = nx_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
			fhp_q <= FW'(ccd_pkg::FLASH_RST);
			ssm_q <= SSW'(ccd_pkg::SPIN_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				ccd_pkg::CFG_LIMIT: lim_q <= lim_sat;
				ccd_pkg::CFG_FLASH: fhp_q <= cfg.data[FW-1:0];
				ccd_pkg::CFG_SPIN:  ssm_q <= cfg.data[SSW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= 1'b0;
			flash_q      <= 1'b0;
			spin_q       <= 1'b0;
			phase_q      <= 1'b0;
			blank_q      <= 1'b0;
			elapsed_q    <= '0;
			nupd_q       <= '0;
			nbeep_q      <= '0;
			shown_q      <= '0;
			spin_idx_q   <= '0;
			spin_wait_q  <= '0;
			flash_wait_q <= '0;
		end else if (acc) begin
			run_q        <= nx_run;
			flash_q      <= nx_flash;
			spin_q       <= nx_spin;
			phase_q      <= nx_phase;
			blank_q      <= nx_blank;
			elapsed_q    <= nx_elapsed;
			nupd_q       <= nx_nupd;
			nbeep_q      <= nx_nbeep;
			shown_q      <= nx_shown;
			spin_idx_q   <= nx_idx;
			spin_wait_q  <= nx_swait;
			flash_wait_q <= nx_fwait;
		end
	end

	a_expire_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && nx_expired) |=> !run_q)
		else $error("timer still running after expiry");

	a_update_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (elapsed_q <= nupd_q))
		else $error("display update schedule fell behind elapsed time");

	a_beep_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (elapsed_q <= nbeep_q))
		else $error("beep schedule fell behind elapsed time");

	a_spin_range: assert property (@(posedge clk) disable iff (!arst_n)
		spin_idx_q <= SIW'(ccd_pkg::SPIN_LAST))
		else $error("spin segment index out of range");

endmodule

// ----- design/ccd_fifo.sv -----
// Short queue between the front end and the digit pipeline.
// Register array with wrap-around pointers. Depends on ccd_pkg.
module ccd_fifo #(
	parameter int WIDTH = ccd_pkg::TIME_WIDTH_DEF + $bits(ccd_pkg::ccd_flags_t),
	parameter int DEPTH = ccd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [WIDTH-1:0]  push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [WIDTH-1:0]  pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/ccd_back.sv -----
// Back end: converts the shown time to MM:SS or SS:hundredths BCD digits in
// a four-stage pipeline ending in the output register. Depends on ccd_pkg, ccd_if.
module ccd_back #(
	parameter int TIME_WIDTH = ccd_pkg::TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TIME_WIDTH-1:0]  in_time,
	input  ccd_pkg::ccd_flags_t    in_flags,
	ccd_out_if.source              result
);

	localparam int TW  = TIME_WIDTH;
	localparam int CW  = ccd_pkg::CONV_W;
	localparam int EW  = (TW > CW) ? TW : CW;
	localparam int PW  = CW + CW;
	localparam int QW  = ccd_pkg::QUOT_W;
	localparam int RW  = ccd_pkg::REM_W;
	localparam int HW  = ccd_pkg::PAIR_W;
	localparam int MW  = ccd_pkg::QUOT_W + ccd_pkg::RECIP_60_W;
	localparam int DW  = ccd_pkg::REM_W + ccd_pkg::RECIP_10_W;

	logic          en;
	logic [EW-1:0] in_ext;
	logic          ovf_in;
	logic [CW-1:0] t_in;

	logic                v_s1, v_s2, v_s3, v_s4;
	ccd_pkg::ccd_flags_t f_s1, f_s2, f_s3, f_s4;
	logic                ovf_s1, ovf_s2;
	logic [CW-1:0]       t_s1;
	logic [PW-1:0]       p_s1;
	logic [QW-1:0]       q_s2;
	logic [RW-1:0]       r_s2;
	logic [MW-1:0]       mp_s2;
	logic [HW-1:0]       hi_s3, lo_s3;
	logic [ccd_pkg::DIGITS_W-1:0] digits_s4;

	logic [QW-1:0] q;
	logic [CW-1:0] q_ms;
	logic [HW-1:0] mins, secs, cents, hi, lo;
	logic [DW-1:0] rd;

	assign en       = !v_s4 || result.ready;
	assign in_ready = en;

	// Anything from 100 minutes up shows as 99:59.
	assign in_ext = EW'(in_time);
	assign ovf_in = in_ext >= EW'(ccd_pkg::SHOW_CLAMP_MS);
	assign t_in   = ovf_in ? '0 : in_ext[CW-1:0];

	assign q    = p_s1[ccd_pkg::RECIP_1000_SH +: QW];
	assign q_ms = CW'(q) * CW'(ccd_pkg::MS_PER_S);

	assign mins  = mp_s2[ccd_pkg::RECIP_60_SH +: HW];
	assign secs  = HW'(q_s2 - QW'(mins) * QW'(ccd_pkg::SEC_PER_MIN));
	assign rd    = DW'(r_s2) * DW'(ccd_pkg::RECIP_10);
	assign cents = rd[ccd_pkg::RECIP_10_SH +: HW];

	always_comb begin
		if (ovf_s2) begin
			hi = HW'(ccd_pkg::TOP_HI);
			lo = HW'(ccd_pkg::TOP_LO);
		end else if (q_s2 >= QW'(ccd_pkg::SEC_PER_MIN)) begin
			hi = mins;
			lo = secs;
		end else begin
			hi = q_s2[HW-1:0];
			lo = cents;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1      <= in_flags;
			ovf_s1    <= ovf_in;
			t_s1      <= t_in;
			p_s1      <= PW'(t_in) * PW'(ccd_pkg::RECIP_1000);
			f_s2      <= f_s1;
			ovf_s2    <= ovf_s1;
			q_s2      <= q;
			r_s2      <= RW'(t_s1 - q_ms);
			mp_s2     <= MW'(q) * MW'(ccd_pkg::RECIP_60);
			f_s3      <= f_s2;
			hi_s3     <= hi;
			lo_s3     <= lo;
			f_s4      <= f_s3;
			digits_s4 <= {ccd_pkg::bcd2(hi_s3), ccd_pkg::bcd2(lo_s3)};
		end
	end

	assign result.valid         = v_s4;
	assign result.digits_bcd    = digits_s4;
	assign result.show_mode     = f_s4.show_mode;
	assign result.spin_segments = f_s4.spin_segments;
	assign result.beep          = f_s4.beep;
	assign result.expired       = f_s4.expired;
	assign result.running       = f_s4.running;

endmodule

// ----- design/countdown_clock_display.sv -----
// Top level of the countdown clock display: front end, queue and digit
// pipeline. Depends on ccd_pkg, ccd_if, ccd_front, ccd_fifo, ccd_back.
//
// Usage
//   item:   valid/ready channel; kind is a 1 ms tick or a command, show_time_ms
//           is read by the show-time command only. Every item gives one result.
//   result: valid/ready channel with the four BCD digits, display mode, spin
//           segment and the beep, expired and running flags after that item.
//   cfg:    write channel, always ready; index 0 time limit in seconds,
//           1 flash half period, 2 spin step. Write only while the block is idle.
//   Throughput is one item per cycle while the queue has room: the front end
//   updates all timer state as each item is accepted.
//   An accepted item passes through a queue entry and then the four stages of
//   the digit conversion pipeline before its result is valid.
//   On reset all state is cleared, limit 0, flash half period 200, spin step
//   60, the queue and pipeline are empty.
//   While result is stalled the pipeline holds, the 4-entry queue fills and
//   then item.ready drops; nothing is lost or repeated.
module countdown_clock_display #(
	parameter int TIME_WIDTH = ccd_pkg::TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ccd_in_if.sink      item,
	ccd_cfg_if.sink     cfg,
	ccd_out_if.source   result
);

	localparam int FLW = $bits(ccd_pkg::ccd_flags_t);
	localparam int QW  = TIME_WIDTH + FLW;

	logic                  fr_valid, fr_ready;
	logic [TIME_WIDTH-1:0] fr_time;
	ccd_pkg::ccd_flags_t   fr_flags;

	logic                  bk_valid, bk_ready;
	logic [QW-1:0]         bk_data;
	logic [TIME_WIDTH-1:0] bk_time;
	ccd_pkg::ccd_flags_t   bk_flags;

	ccd_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.q_valid (fr_valid),
		.q_ready (fr_ready),
		.q_time  (fr_time),
		.q_flags (fr_flags)
	);

	ccd_fifo #(
		.WIDTH (QW),
		.DEPTH (ccd_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  ({fr_time, fr_flags}),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	assign bk_time  = bk_data[QW-1 -: TIME_WIDTH];
	assign bk_flags = ccd_pkg::ccd_flags_t'(bk_data[FLW-1:0]);

	ccd_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_ready (bk_ready),
		.in_time  (bk_time),
		.in_flags (bk_flags),
		.result   (result)
	);

endmodule

// ----- sim/countdown_clock_display_tb.sv -----
// Testbench for countdown_clock_display: directed and random ticks and commands,
// each result checked against an in-bench model of the timer and display.
// Depends on ccd_pkg, ccd_if and the countdown_clock_display RTL.
module countdown_clock_display_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TIME_MAX = (1 << ccd_pkg::TIME_WIDTH_DEF) - 1;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1150;
	localparam int LONG_RUN_TICKS = 1100;
	localparam int MAX_REPORTS = 10;
	localparam logic [ccd_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

	typedef struct packed {
		logic [ccd_pkg::DIGITS_W-1:0] digits;
		ccd_pkg::ccd_mode_t           mode;
		logic [ccd_pkg::SEG_W-1:0]    segs;
		logic                         beep;
		logic                         expired;
		logic                         running;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	ccd_in_if  item();
	ccd_cfg_if cfg();
	ccd_out_if result();

	countdown_clock_display dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg(cfg),
		.result(result)
	);

	always #5 clk = ~clk;

	// timer model
	int unsigned limit_s, flash_half, spin_step;
	bit cd_run, cd_flash, cd_spin, flash_on, blanked;
	int unsigned elapsed, update_due, beep_due, shown_ms;
	logic [ccd_pkg::DIGITS_W-1:0] shown_bcd;
	int unsigned seg_idx, seg_wait, flash_wait;

	status_t pending_status[$];
	status_t got, want;
	int failures = 0;
	int stall_cycles = 0;
	int gap_max;

	function automatic int unsigned sat_ms(longint unsigned v);
		return (v > TIME_MAX) ? TIME_MAX : int'(v);
	endfunction

	function automatic void reset_model();
		limit_s = 0;
		flash_half = ccd_pkg::FLASH_RST;
		spin_step = ccd_pkg::SPIN_RST;
		{cd_run, cd_flash, cd_spin, flash_on, blanked} = '0;
		elapsed = 0;
		update_due = 0;
		beep_due = 0;
		shown_ms = 0;
		shown_bcd = '0;
		seg_idx = 0;
		seg_wait = 0;
		flash_wait = 0;
	endfunction

	function automatic void show_ms(int unsigned t);
		int unsigned hi, lo;
		cd_spin = 1'b0;
		blanked = 1'b0;
		shown_ms = t;
		if (t >= ccd_pkg::FINE_ZONE_MS) begin
			if (t / ccd_pkg::FINE_ZONE_MS > ccd_pkg::TOP_HI) begin
				hi = ccd_pkg::TOP_HI;
				lo = ccd_pkg::TOP_LO;
			end else begin
				hi = t / ccd_pkg::FINE_ZONE_MS;
				lo = (t / ccd_pkg::MS_PER_S) % ccd_pkg::SEC_PER_MIN;
			end
		end else begin
			hi = t / ccd_pkg::MS_PER_S;
			lo = (t / ccd_pkg::FINE_STEP) % 100;
		end
		shown_bcd = {4'(hi / 10), 4'(hi % 10), 4'(lo / 10), 4'(lo % 10)};
	endfunction

	function automatic void flash_toggle();
		flash_on = !flash_on;
		if (flash_on)
			show_ms(shown_ms);
		else
			blanked = 1'b1;
		flash_wait = flash_half;
	endfunction

	function automatic void run_tick(inout bit beep, inout bit expired);
		int unsigned lim, step;
		lim = sat_ms(64'(limit_s) * ccd_pkg::MS_PER_S);
		if (elapsed < TIME_MAX)
			elapsed++;
		if (elapsed >= lim) begin
			show_ms(0);
			cd_run = 1'b0;
			expired = 1'b1;
			return;
		end
		if (elapsed >= update_due) begin
			step = (lim - elapsed <= ccd_pkg::FINE_ZONE_MS) ? ccd_pkg::FINE_STEP
				: ccd_pkg::MS_PER_S;
			show_ms(lim - update_due);
			update_due = sat_ms(64'(update_due)
				+ 64'(step) * 64'((elapsed - update_due) / step + 1));
		end
		if (elapsed >= beep_due) begin
			beep = 1'b1;
			beep_due = sat_ms(64'(beep_due) + ccd_pkg::MS_PER_S);
		end
	endfunction

	function automatic status_t advance_countdown(logic [ccd_pkg::KIND_W-1:0] k,
		logic [ccd_pkg::SHOW_W-1:0] st);
		status_t s;
		bit beep, expired;
		beep = 1'b0;
		expired = 1'b0;
		case (k)
			ccd_pkg::KIND_TICK: begin
				if (cd_run)
					run_tick(beep, expired);
				if (cd_flash) begin
					if (flash_wait <= 1)
						flash_toggle();
					else
						flash_wait--;
				end
				if (cd_spin) begin
					if (seg_wait <= 1) begin
						seg_idx = (seg_idx >= ccd_pkg::SPIN_LAST) ? 0 : seg_idx + 1;
						seg_wait = spin_step;
					end else begin
						seg_wait--;
					end
				end
			end
			ccd_pkg::KIND_START: begin
				elapsed = 0;
				update_due = 0;
				beep_due = 0;
				cd_run = 1'b1;
				cd_flash = 1'b0;
			end
			ccd_pkg::KIND_STOP: cd_run = 1'b0;
			ccd_pkg::KIND_RESET: begin
				cd_run = 1'b0;
				cd_flash = 1'b0;
				cd_spin = 1'b0;
				show_ms(sat_ms(64'(limit_s) * ccd_pkg::MS_PER_S));
			end
			ccd_pkg::KIND_SPIN: begin
				cd_spin = 1'b1;
				cd_flash = 1'b0;
				seg_idx = 0;
				seg_wait = spin_step;
			end
			ccd_pkg::KIND_FLASH: begin
				cd_flash = 1'b1;
				flash_toggle();
			end
			ccd_pkg::KIND_SHOW: show_ms(32'(st));
			default: ;
		endcase
		s.digits = shown_bcd;
		s.mode = cd_spin ? ccd_pkg::MODE_SPIN
			: (blanked ? ccd_pkg::MODE_BLANK : ccd_pkg::MODE_DIGITS);
		s.segs = cd_spin ? ccd_pkg::SEG_W'(1 << seg_idx) : '0;
		s.beep = beep;
		s.expired = expired;
		s.running = cd_run;
		return s;
	endfunction

	task automatic push_item(logic [ccd_pkg::KIND_W-1:0] k, logic [ccd_pkg::SHOW_W-1:0] st);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.kind <= k;
		item.show_time_ms <= st;
		do @(posedge clk); while (!item.ready);
		pending_status.push_back(advance_countdown(k, st));
	endtask

	task automatic settle();
		item.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(logic [ccd_pkg::CFG_IDX_W-1:0] idx,
		logic [ccd_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			ccd_pkg::CFG_LIMIT: limit_s = 32'(data);
			ccd_pkg::CFG_FLASH: flash_half = 32'(data[ccd_pkg::FLASH_W-1:0]);
			ccd_pkg::CFG_SPIN:  spin_step = 32'(data[ccd_pkg::SPINSTEP_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic program_timer(logic [ccd_pkg::CFG_DATA_W-1:0] lim,
		logic [ccd_pkg::CFG_DATA_W-1:0] fl, logic [ccd_pkg::CFG_DATA_W-1:0] sp);
		settle();
		cfg_beat(ccd_pkg::CFG_LIMIT, lim);
		cfg_beat(ccd_pkg::CFG_FLASH, fl);
		cfg_beat(ccd_pkg::CFG_SPIN, sp);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [ccd_pkg::SHOW_W-1:0] pick_show();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return ccd_pkg::SHOW_W'($urandom_range(ccd_pkg::SHOW_CLAMP_MS, TIME_MAX));
		else if (r == 1)
			return ccd_pkg::SHOW_W'($urandom_range(0, ccd_pkg::FINE_ZONE_MS - 1));
		return ccd_pkg::SHOW_W'($urandom_range(0, ccd_pkg::SHOW_CLAMP_MS - 1));
	endfunction

	function automatic logic [ccd_pkg::CFG_DATA_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return '0;
			2, 3: return ccd_pkg::CFG_DATA_W'($urandom_range(1, 2));
			4, 5, 6: return ccd_pkg::CFG_DATA_W'($urandom_range(3, 70));
			7: return ccd_pkg::CFG_DATA_W'(5999);
			8: return '1;
			default: return ccd_pkg::CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [ccd_pkg::CFG_DATA_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return ccd_pkg::CFG_DATA_W'(1);
			2: return '1;
			3: return ccd_pkg::CFG_DATA_W'($urandom);
			default: return ccd_pkg::CFG_DATA_W'($urandom_range(1, 25));
		endcase
	endfunction

	function automatic logic [ccd_pkg::KIND_W-1:0] pick_kind(bit long_run);
		int r;
		r = $urandom_range(0, 99);
		if (long_run) begin
			if (r < 97) return ccd_pkg::KIND_TICK;
			if (r == 97) return ccd_pkg::KIND_FLASH;
			if (r == 98) return ccd_pkg::KIND_SPIN;
			return ccd_pkg::KIND_SHOW;
		end
		if (r < 72) return ccd_pkg::KIND_TICK;
		if (r < 78) return ccd_pkg::KIND_START;
		if (r < 81) return ccd_pkg::KIND_STOP;
		if (r < 85) return ccd_pkg::KIND_RESET;
		if (r < 88) return ccd_pkg::KIND_SPIN;
		if (r < 92) return ccd_pkg::KIND_FLASH;
		if (r < 97) return ccd_pkg::KIND_SHOW;
		return KIND_UNUSED;
	endfunction

	task automatic test_reset_state();
		push_item(KIND_UNUSED, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_STOP, pick_show());
	endtask

	task automatic test_display_format();
		program_timer('1, ccd_pkg::CFG_DATA_W'(ccd_pkg::FLASH_RST),
			ccd_pkg::CFG_DATA_W'(ccd_pkg::SPIN_RST));
		push_item(ccd_pkg::KIND_SHOW, '0);
		push_item(ccd_pkg::KIND_SHOW, ccd_pkg::SHOW_W'(ccd_pkg::FINE_ZONE_MS - 1));
		push_item(ccd_pkg::KIND_SHOW, ccd_pkg::SHOW_W'(ccd_pkg::FINE_ZONE_MS));
		push_item(ccd_pkg::KIND_SHOW, ccd_pkg::SHOW_W'(ccd_pkg::SHOW_CLAMP_MS - 1));
		push_item(ccd_pkg::KIND_SHOW, '1);
		push_item(ccd_pkg::KIND_RESET, '0);
	endtask

	task automatic test_spin_and_flash();
		program_timer(ccd_pkg::CFG_DATA_W'(2), '0, '0);
		push_item(ccd_pkg::KIND_SPIN, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_FLASH, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_SHOW, ccd_pkg::SHOW_W'(1234));
		push_item(ccd_pkg::KIND_FLASH, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_FLASH, pick_show());
		push_item(ccd_pkg::KIND_RESET, pick_show());
	endtask

	task automatic test_countdown();
		program_timer('0, '1, '1);
		push_item(ccd_pkg::KIND_START, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		program_timer(ccd_pkg::CFG_DATA_W'(5999), '1, '1);
		push_item(ccd_pkg::KIND_START, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_STOP, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		push_item(ccd_pkg::KIND_START, pick_show());
		push_item(ccd_pkg::KIND_TICK, pick_show());
		// shorter limit while running: next tick expires
		program_timer('0, '1, '1);
		push_item(ccd_pkg::KIND_TICK, pick_show());
	endtask

	task automatic test_random_mix();
		int total, n, phase;
		bit long_run;
		logic [ccd_pkg::CFG_DATA_W-1:0] lim;
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			long_run = (phase == 0);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			// one long countdown crosses the coarse/fine boundary, then expires on rewrite
			if (long_run)
				lim = ccd_pkg::CFG_DATA_W'(61);
			else if (phase == 1)
				lim = '0;
			else
				lim = pick_limit();
			program_timer(lim, pick_period(), pick_period());
			if (long_run) begin
				push_item(ccd_pkg::KIND_RESET, pick_show());
				push_item(ccd_pkg::KIND_START, pick_show());
				n = LONG_RUN_TICKS;
			end else begin
				n = $urandom_range(60, 200);
			end
			total += n;
			repeat (n) push_item(pick_kind(long_run), pick_show());
			phase++;
		end
		gap_max = 15;
	endtask

	initial begin
		int stall;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, gap_max);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			got.digits = result.digits_bcd;
			got.mode = ccd_pkg::ccd_mode_t'(result.show_mode);
			got.segs = result.spin_segments;
			got.beep = result.beep;
			got.expired = result.expired;
			got.running = result.running;
			if (pending_status.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("unexpected result transfer: digits=%h mode=%0d", got.digits,
						got.mode);
				failures++;
			end else begin
				want = pending_status.pop_front();
				if (got.digits !== want.digits || got.mode !== want.mode
					|| got.segs !== want.segs || got.beep !== want.beep
					|| got.expired !== want.expired || got.running !== want.running) begin
					if (failures < MAX_REPORTS) begin
						$display("mismatch exp: digits=%h mode=%0d segs=%b beep=%b exp=%b run=%b",
							want.digits, want.mode, want.segs, want.beep, want.expired,
							want.running);
						$display("         got: digits=%h mode=%0d segs=%b beep=%b exp=%b run=%b",
							got.digits, got.mode, got.segs, got.beep, got.expired,
							got.running);
					end
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("countdown_clock_display test failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		item.valid <= 1'b0;
		item.kind <= ccd_pkg::KIND_TICK;
		item.show_time_ms <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= ccd_pkg::CFG_LIMIT;
		cfg.data <= '0;
		gap_max = 15;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_display_format();
		test_spin_and_flash();
		test_countdown();
		test_random_mix();
		settle();
		if (failures == 0 && pending_status.size() == 0)
			$display("countdown_clock_display test passed");
		else
			$display("countdown_clock_display test failed");
		$finish;
	end

endmodule
